@@ rtl/core/npcm_pkg.sv @@
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared types, constants and helpers of the nearest palette color mapper.
// ----------------------------------------------------------------------------
package npcm_pkg;

    // Default parameter values of the top level.
    localparam int unsigned DEF_PALETTE_ROWS = 4;
    localparam int unsigned DEF_MAX_COLS     = 255;
    localparam int unsigned DEF_CHANNEL_BITS = 8;

    // Fixed field widths of the stream words.
    localparam int unsigned ROW_FW   = 2;
    localparam int unsigned COL_W    = 8;
    localparam int unsigned CHAN_FW  = 8;
    localparam int unsigned NUM_CHAN = 4;

    // Input word layout, lowest bit first.
    localparam int unsigned ROW_LSB  = 0;
    localparam int unsigned COL_LSB  = ROW_LSB + ROW_FW;
    localparam int unsigned CHAN_LSB = COL_LSB + COL_W;
    localparam int unsigned S_FIELDS_W = CHAN_LSB + NUM_CHAN * CHAN_FW;
    localparam int unsigned S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;

    // Configuration port.
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_PALETTE_COLS  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ACTIVE_ROW    = 2'd2;

    localparam int unsigned CCNT_W = 3;

    localparam logic [COL_W-1:0]  RST_PALETTE_COLS  = 8'd16;
    localparam logic [CCNT_W-1:0] RST_CHANNEL_COUNT = 3'd3;
    localparam logic [ROW_FW-1:0] RST_ACTIVE_ROW    = 2'd0;

    // Request kinds carried in tuser.
    localparam logic REQ_LOAD     = 1'b0;
    localparam logic REQ_CLASSIFY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } npcm_state_t;

    // One candidate entry handed to the distance unit.
    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] col;
    } npcm_cand_t;

    // Status returned by the distance unit.
    typedef struct packed {
        logic             busy;
        logic [COL_W-1:0] best;
    } npcm_stat_t;

    // Folds a row field into the row range by repeated subtraction; the
    // field is below four, so three steps cover a single row as well.
    function automatic logic [4:0] wrap_row(input logic [ROW_FW-1:0] r,
                                            input int unsigned rows);
        logic [4:0] v;
        v = 5'(r);
        for (int i = 0; i < 3; i++) begin
            if (32'(v) >= rows) begin
                v = v - 5'(rows);
            end
        end
        return v;
    endfunction

endpackage

@@ rtl/core/nearest_palette_color_mapper.sv @@
// ----------------------------------------------------------------------------
// nearest_palette_color_mapper
// Stores a color palette and maps each pixel to its nearest palette entry.
// ----------------------------------------------------------------------------
// A word on the input stream is either a palette load (tuser low) or a pixel
// to classify (tuser high). A load writes one entry, at the row and column it
// names, into a single-port-per-side palette memory and produces
// no output word; a load whose column is not below MAX_COLS is dropped. A
// classify word walks the row chosen by active_row from column 0 up to
// palette_cols-1 (at most MAX_COLS), reading one entry per cycle from the
// palette memory, and returns the column with the smallest squared distance
// over the first channel_count channels, the lowest column winning ties and 0
// when no column is searched. From acceptance until the next word can be
// accepted, a classify passes through one memory read per column, the
// draining of the read and distance stages, the detection of the scan's
// end, the hand-off of the index to the output register and the return to
// idle, where the next word is accepted. The hand-off stalls for as long
// as the output register still holds an earlier result that has not been
// taken. A load leaves the block idle, so loads can follow each other with
// no gap. The result sits in an output register, so the next word is
// accepted while the previous result still waits. Palette entries have no
// reset value: a classify must only reach entries written since reset.
// Configuration registers are to be written over the APB port only while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module nearest_palette_color_mapper #(
    parameter int unsigned PALETTE_ROWS = npcm_pkg::DEF_PALETTE_ROWS,
    parameter int unsigned MAX_COLS     = npcm_pkg::DEF_MAX_COLS,
    parameter int unsigned CHANNEL_BITS = npcm_pkg::DEF_CHANNEL_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // APB configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [npcm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [npcm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [npcm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // entry_row[1:0], entry_index[9:2], chan_0[17:10], chan_1[25:18],
    // chan_2[33:26], chan_3[41:34], zero fill above.
    input  logic [npcm_pkg::S_DATA_W-1:0]       s_tdata,
    // req_type: low for a palette load, high for a pixel to classify.
    input  logic                                s_tuser,
    // Output stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // nearest_index[7:0].
    output logic [npcm_pkg::COL_W-1:0]          m_tdata
);
    import npcm_pkg::*;

    localparam int unsigned DEPTH = PALETTE_ROWS * MAX_COLS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned RW    = (PALETTE_ROWS > 1) ? $clog2(PALETTE_ROWS) : 1;
    localparam int unsigned EW    = NUM_CHAN * CHANNEL_BITS;

    // Configuration registers.
    logic [COL_W-1:0]     palette_cols_reg;
    logic [CCNT_W-1:0]    channel_count_reg;
    logic [ROW_FW-1:0]    active_row_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_we;

    // Input word fields.
    logic [ROW_FW-1:0]    in_row;
    logic [COL_W-1:0]     in_col;
    logic [EW-1:0]        in_entry;
    logic                 in_accept;
    logic                 load_we;
    logic                 start;

    // Sequencer.
    npcm_state_t          state_reg;
    npcm_state_t          state_next;
    logic [COL_W-1:0]     col_reg;
    logic [COL_W-1:0]     cols_reg;
    logic [RW-1:0]        row_sel_reg;
    logic [EW-1:0]        pix_reg;
    logic [NUM_CHAN-1:0]  ch_en_reg;
    logic                 issue;
    logic                 scan_done;
    logic                 out_free;
    logic                 out_load;

    // Palette memory.
    logic [EW-1:0]        pal_mem [DEPTH];
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic [EW-1:0]        rd_data_reg;
    logic                 rd_valid_reg;
    logic [COL_W-1:0]     rd_col_reg;

    npcm_cand_t           cand;
    npcm_stat_t           stat;

    logic                 m_tvalid_reg;
    logic [COL_W-1:0]     m_tdata_reg;

    // ------------------------------------------------------------------
    // APB registers. Writes complete in the access cycle; reads return
    // the stored values zero extended.
    // ------------------------------------------------------------------
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_we  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_cols_reg  <= RST_PALETTE_COLS;
            channel_count_reg <= RST_CHANNEL_COUNT;
            active_row_reg    <= RST_ACTIVE_ROW;
        end
        else if (cfg_we)
        begin
            case (reg_idx)
                REG_PALETTE_COLS:  palette_cols_reg  <= pwdata[COL_W-1:0];
                REG_CHANNEL_COUNT: channel_count_reg <= pwdata[CCNT_W-1:0];
                REG_ACTIVE_ROW:    active_row_reg    <= pwdata[ROW_FW-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_PALETTE_COLS:  prdata = APB_DATA_W'(palette_cols_reg);
            REG_CHANNEL_COUNT: prdata = APB_DATA_W'(channel_count_reg);
            REG_ACTIVE_ROW:    prdata = APB_DATA_W'(active_row_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input word unpacking. Channels are cut to CHANNEL_BITS bits, or
    // zero extended when CHANNEL_BITS is wider than the field.
    // ------------------------------------------------------------------
    assign in_row = s_tdata[ROW_LSB +: ROW_FW];
    assign in_col = s_tdata[COL_LSB +: COL_W];

    always_comb
    begin
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            in_entry[k*CHANNEL_BITS +: CHANNEL_BITS] =
                CHANNEL_BITS'(s_tdata[CHAN_LSB + k*CHAN_FW +: CHAN_FW]);
        end
    end

    assign in_accept = s_tvalid && s_tready;
    assign load_we   = in_accept && (s_tuser == REQ_LOAD) && (32'(in_col) < MAX_COLS);
    assign start     = in_accept && (s_tuser == REQ_CLASSIFY);

    // Entries are laid out row after row, MAX_COLS entries to a row.
    assign wr_addr = AW'(RW'(wrap_row(in_row, PALETTE_ROWS))) * AW'(MAX_COLS)
                     + AW'(in_col);
    assign rd_addr = AW'(row_sel_reg) * AW'(MAX_COLS) + AW'(col_reg);

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            pal_mem[wr_addr] <= in_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg <= pal_mem[rd_addr];
        end
        rd_col_reg <= col_reg;
    end

    // ------------------------------------------------------------------
    // Per-classify context, latched at acceptance. The column limit is
    // clamped to MAX_COLS and the channel enables follow channel_count,
    // which saturates at four channels by construction.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            pix_reg     <= in_entry;
            row_sel_reg <= RW'(wrap_row(active_row_reg, PALETTE_ROWS));
            cols_reg    <= (32'(palette_cols_reg) > MAX_COLS) ? COL_W'(MAX_COLS)
                                                              : palette_cols_reg;
            for (int k = 0; k < NUM_CHAN; k++)
            begin
                ch_en_reg[k] <= (CCNT_W'(k) < channel_count_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            col_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= issue;
            if (start)
            begin
                col_reg <= '0;
            end
            else if (issue)
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // The scan is over once every column is issued and the read and
    // distance stages hold nothing; the running minimum is then final.
    assign scan_done = (col_reg >= cols_reg) && !rd_valid_reg && !stat.busy;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        issue    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_SCAN:
            begin
                issue = (col_reg < cols_reg);
            end
            ST_FIN:
            begin
                out_load = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign cand.valid = rd_valid_reg;
    assign cand.col   = rd_col_reg;

    npcm_dist #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .ch_en (ch_en_reg),
        .pixel (pix_reg),
        .entry (rd_data_reg),
        .cand  (cand),
        .stat  (stat)
    );

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= stat.best;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ rtl/core/npcm_dist.sv @@
// ----------------------------------------------------------------------------
// npcm_dist
// Two-stage squared-distance unit with a running minimum over candidates.
// ----------------------------------------------------------------------------
module npcm_dist #(
    parameter int unsigned CHANNEL_BITS = npcm_pkg::DEF_CHANNEL_BITS
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    input  logic [npcm_pkg::NUM_CHAN-1:0]               ch_en,
    input  logic [npcm_pkg::NUM_CHAN*CHANNEL_BITS-1:0]  pixel,
    input  logic [npcm_pkg::NUM_CHAN*CHANNEL_BITS-1:0]  entry,
    input  npcm_pkg::npcm_cand_t                        cand,
    output npcm_pkg::npcm_stat_t                        stat
);
    import npcm_pkg::*;

    localparam int unsigned SQ_W = 2 * CHANNEL_BITS;
    localparam int unsigned DW   = SQ_W + 2;

    logic [SQ_W-1:0]   sq_reg [NUM_CHAN];
    logic              s1_valid_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [DW-1:0]     best_reg;
    logic              have_reg;
    logic [COL_W-1:0]  best_idx_reg;
    logic [DW-1:0]     dist_sum;

    // Stage one: absolute difference and square per channel.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            logic [CHANNEL_BITS-1:0] a;
            logic [CHANNEL_BITS-1:0] b;
            logic [CHANNEL_BITS-1:0] d;
            a = pixel[k*CHANNEL_BITS +: CHANNEL_BITS];
            b = entry[k*CHANNEL_BITS +: CHANNEL_BITS];
            d = (a > b) ? (a - b) : (b - a);
            sq_reg[k] <= ch_en[k] ? (SQ_W'(d) * SQ_W'(d)) : '0;
        end
        s1_col_reg <= cand.col;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cand.valid;
        end
    end

    always_comb
    begin
        dist_sum = '0;
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            dist_sum = dist_sum + DW'(sq_reg[k]);
        end
    end

    // Stage two: strict less-than keeps the lowest index on ties.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg     <= 1'b0;
            best_idx_reg <= '0;
        end
        else if (start)
        begin
            have_reg     <= 1'b0;
            best_idx_reg <= '0;
        end
        else if (s1_valid_reg && (!have_reg || dist_sum < best_reg))
        begin
            have_reg     <= 1'b1;
            best_idx_reg <= s1_col_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && (!have_reg || dist_sum < best_reg))
        begin
            best_reg <= dist_sum;
        end
    end

    assign stat.busy = s1_valid_reg;
    assign stat.best = best_idx_reg;

endmodule

@@ tb/nearest_palette_color_mapper_tb.sv @@
// ----------------------------------------------------------------------------
// nearest_palette_color_mapper_tb
// Self-checking testbench for the nearest palette color mapper.
// ----------------------------------------------------------------------------
// Palette loads and pixel classifications are streamed into the block, with
// random input gaps and output back-pressure outside the steady phases.
// A predictor in this file keeps its own copy of the palette and of the three
// configuration registers. For every accepted classify word it computes the
// nearest palette index, and each output word is checked against the oldest
// pending index. The register settings change between phases, only while the
// block has drained. Classify words are only sent once every entry they scan
// has been loaded: the stimulus fills missing entries first.
// ----------------------------------------------------------------------------
module nearest_palette_color_mapper_tb;

    import npcm_pkg::*;

    localparam int unsigned ROWS       = DEF_PALETTE_ROWS;
    localparam int unsigned COLS       = DEF_MAX_COLS;
    localparam int unsigned WORD_GOAL  = 1100;
    localparam int unsigned CYCLE_CAP  = 2_000_000;
    // The tail wait covers the longest full-row scan plus some margin for a
    // stray output word.
    localparam int unsigned TAIL_WAIT  = 300;

    typedef logic [NUM_CHAN-1:0][CHAN_FW-1:0] color_t;

    // One word of the input stream before it is packed into tdata.
    typedef struct packed {
        logic              kind;
        logic [ROW_FW-1:0] row;
        logic [COL_W-1:0]  col;
        color_t            chan;
    } pal_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // entry_row[1:0], entry_index[9:2], chan_0..chan_3 from bit 10 up.
    logic [S_DATA_W-1:0]   s_tdata = '0;
    // req_type: low for a palette load, high for a pixel to classify.
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // nearest_index[7:0].
    logic [COL_W-1:0]      m_tdata;

    nearest_palette_color_mapper dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Words waiting for the driver, and indexes waiting for the monitor.
    pal_word_t        word_q[$];
    logic [COL_W-1:0] nearest_q[$];

    // Predictor state: palette contents as accepted by the block, and the
    // register values as last written over APB.
    color_t            pal_mem [ROWS][COLS];
    logic [COL_W-1:0]  cfg_cols  = RST_PALETTE_COLS;
    logic [CCNT_W-1:0] cfg_chans = RST_CHANNEL_COUNT;
    logic [ROW_FW-1:0] cfg_row   = RST_ACTIVE_ROW;

    // Stimulus-side view of the palette, used to avoid scanning entries that
    // were never loaded and to aim pixels close to existing entries.
    bit                gen_written [ROWS][COLS];
    color_t            gen_pal [ROWS][COLS];

    int unsigned words_sent = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    bit          steady = 1'b0;   // no gaps and no back-pressure when set

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Squared-distance search over the active row. A strict less-than keeps
    // the lowest column on ties; an empty search or zero channels gives 0.
    function automatic logic [COL_W-1:0] nearest_entry(input color_t px);
        int unsigned       span;
        int unsigned       nch;
        longint unsigned   best;
        longint unsigned   sq_sum;
        longint            d;
        logic [COL_W-1:0]  idx;
        span = (cfg_cols > COLS) ? COLS : cfg_cols;
        nch  = (cfg_chans > NUM_CHAN) ? NUM_CHAN : cfg_chans;
        best = 64'hFFFF_FFFF_FFFF_FFFF;
        idx  = '0;
        for (int p = 0; p < span; p++) begin
            sq_sum = 0;
            for (int k = 0; k < nch; k++) begin
                d = longint'(px[k]) - longint'(pal_mem[cfg_row][p][k]);
                sq_sum += longint'(d * d);
            end
            if (sq_sum < best) begin
                best = sq_sum;
                idx  = COL_W'(p);
            end
        end
        return idx;
    endfunction

    // Applies one accepted input word to the predictor. The word is decoded
    // from the bus itself, so a packing error shows up as a mismatch.
    task automatic predict_word(input logic kind, input logic [S_DATA_W-1:0] data);
        logic [ROW_FW-1:0] row;
        logic [COL_W-1:0]  col;
        color_t            px;
        row = data[ROW_LSB +: ROW_FW];
        col = data[COL_LSB +: COL_W];
        px  = data[CHAN_LSB +: NUM_CHAN*CHAN_FW];
        if (kind == REQ_LOAD) begin
            // Loads past the last column are dropped by the block.
            if (col < COLS) begin
                pal_mem[row][col] = px;
            end
        end else begin
            nearest_q.push_back(nearest_entry(px));
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("ERROR cycle %0d: %s", cycles, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Input driver: presents the next queued word, holds it until accepted,
    // and inserts random gaps unless the current phase runs steady.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        pal_word_t w;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tuser  <= REQ_LOAD;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_word(s_tuser, s_tdata);
            end
            if (!s_tvalid || s_tready) begin
                if (word_q.size() != 0 && (steady || $urandom_range(0, 99) >= 25)) begin
                    w = word_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= w.kind;
                    s_tdata  <= S_DATA_W'({w.chan, w.col, w.row});
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor: random back-pressure unless the current phase runs steady,
    // and every accepted word is compared with the oldest predicted index.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        logic [COL_W-1:0] want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(0, 99) >= 25);
            if (m_tvalid && m_tready) begin
                if (nearest_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected output word, index %0d", m_tdata));
                end else begin
                    want = nearest_q.pop_front();
                    if (m_tdata !== want) begin
                        report_mismatch($sformatf("nearest_index got %0d, want %0d",
                                                  m_tdata, want));
                    end
                end
            end
        end
    end

    // Watchdog: a hung block ends the run here.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("nearest_palette_color_mapper: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Channel values lean toward a coarse grid so that equal distances, and
    // therefore ties, turn up often.
    function automatic color_t rand_color();
        color_t c;
        for (int k = 0; k < NUM_CHAN; k++) begin
            if ($urandom_range(0, 1) == 0) begin
                c[k] = CHAN_FW'($urandom_range(0, 255));
            end else begin
                c[k] = CHAN_FW'(85 * $urandom_range(0, 3));
            end
        end
        return c;
    endfunction

    task automatic push_load(input int unsigned row, input int unsigned col,
                             input color_t c);
        pal_word_t w;
        w.kind = REQ_LOAD;
        w.row  = ROW_FW'(row);
        w.col  = COL_W'(col);
        w.chan = c;
        word_q.push_back(w);
        if (col < COLS) begin
            gen_written[row][col] = 1'b1;
            gen_pal[row][col]     = c;
            words_sent++;
        end
    endtask

    // Row and column are unused by a classify word, so they carry noise.
    task automatic push_pixel(input color_t c);
        pal_word_t w;
        w.kind = REQ_CLASSIFY;
        w.row  = ROW_FW'($urandom_range(0, 3));
        w.col  = COL_W'($urandom_range(0, 255));
        w.chan = c;
        word_q.push_back(w);
        words_sent++;
    endtask

    // Sends a pixel if every entry of the scan is loaded; otherwise loads the
    // lowest missing entry instead, so a classify never reads a blank entry.
    task automatic gen_classify();
        int unsigned span;
        int          hole;
        int          v;
        color_t      c;
        span = (cfg_cols > COLS) ? COLS : cfg_cols;
        hole = -1;
        for (int p = span - 1; p >= 0; p--) begin
            if (!gen_written[cfg_row][p]) begin
                hole = p;
            end
        end
        if (hole >= 0) begin
            push_load(cfg_row, hole, rand_color());
        end else if (span != 0 && $urandom_range(0, 99) < 40) begin
            // Aim near an existing entry with a little noise.
            c = gen_pal[cfg_row][$urandom_range(0, span - 1)];
            for (int k = 0; k < NUM_CHAN; k++) begin
                v = int'(c[k]) + $urandom_range(0, 6) - 3;
                c[k] = (v < 0) ? '0 : (v > 255) ? '1 : CHAN_FW'(v);
            end
            push_pixel(c);
        end else begin
            push_pixel(rand_color());
        end
    endtask

    // Waits until every queued word went in and every result came out, lets
    // a load that produces no output settle, and checks again in case a word
    // left the queue in the very cycle that was sampled.
    task automatic wait_drained();
        do begin
            while (word_q.size() != 0 || s_tvalid || nearest_q.size() != 0) begin
                @(posedge clk);
            end
            repeat (20) @(posedge clk);
        end while (word_q.size() != 0 || s_tvalid || nearest_q.size() != 0);
    endtask

    // Setup cycle, access cycle; the register takes the value at the edge
    // that closes the access cycle.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [APB_DATA_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PALETTE_COLS:  cfg_cols  = val[COL_W-1:0];
            REG_CHANNEL_COUNT: cfg_chans = val[CCNT_W-1:0];
            REG_ACTIVE_ROW:    cfg_row   = val[ROW_FW-1:0];
            default: ;
        endcase
    endtask

    task automatic set_mode(input int unsigned cols, input int unsigned nch,
                            input int unsigned row);
        wait_drained();
        write_reg(REG_PALETTE_COLS, APB_DATA_W'(cols));
        write_reg(REG_CHANNEL_COUNT, APB_DATA_W'(nch));
        write_reg(REG_ACTIVE_ROW, APB_DATA_W'(row));
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned phase;
        int unsigned big_scans;
        int unsigned n;
        int unsigned cols;
        int unsigned nch;
        int unsigned r;
        int unsigned hi;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty search: nothing is scanned, both pixels map to 0.
        set_mode(0, 4, 0);
        push_pixel('0);
        push_pixel('1);

        // A small row 0 with a duplicate of entry 0 at entry 2, a load past
        // the last column that must be dropped, the store's far corner and a row 2 entry.
        set_mode(4, 4, 0);
        push_load(0, 0, '0);
        push_load(0, 1, '1);
        push_load(0, 2, '0);
        push_load(0, 3, 32'h7ffe_0180);
        push_load(0, 255, 32'haaaa_aaaa);
        push_load(3, 254, '1);
        push_load(2, 128, 32'h55aa_55aa);
        push_pixel('0);                 // tie between entries 0 and 2
        push_pixel('1);
        push_pixel(32'h7ffe_0180);
        push_pixel(32'h4040_4040);

        // No channel compared: every distance is zero.
        set_mode(4, 0, 0);
        push_pixel(32'h1234_5678);

        // A channel count above four behaves like four.
        set_mode(4, 7, 0);
        push_pixel('1);
        push_pixel(32'h80fd_0281);

        // Only the first channel counts.
        set_mode(4, 1, 0);
        push_pixel(32'h0000_00ff);
        push_pixel('0);

        // Random phases. Most scans are short; at most two walk a full or near-full row.
        phase     = 0;
        big_scans = 0;
        while (words_sent < WORD_GOAL) begin
            r = $urandom_range(0, 99);
            if (r < 6 && big_scans < 2) begin
                cols = ($urandom_range(0, 1) == 0) ? 255 : 254;
                big_scans++;
            end else if (r < 14) begin
                cols = $urandom_range(0, 2);
            end else begin
                cols = $urandom_range(3, 24);
            end
            r = $urandom_range(0, 99);
            if (r < 10) begin
                nch = 0;
            end else if (r < 20) begin
                nch = $urandom_range(5, 7);
            end else begin
                nch = $urandom_range(1, 4);
            end
            set_mode(cols, nch, $urandom_range(0, 3));
            steady = (phase % 6 == 3);
            n = $urandom_range(20, 60);
            for (int i = 0; i < n; i++) begin
                r = $urandom_range(0, 99);
                if (r < 30) begin
                    // Loads mostly land near the scanned range, a few land
                    // on the dropped column past the end of the row.
                    r  = $urandom_range(0, 99);
                    hi = (cols + 8 > COLS - 1) ? COLS - 1 : cols + 8;
                    if (r < 5) begin
                        push_load($urandom_range(0, 3), 255, rand_color());
                    end else if (r < 60) begin
                        push_load($urandom_range(0, 3), $urandom_range(0, hi),
                                  rand_color());
                    end else begin
                        push_load($urandom_range(0, 3), $urandom_range(0, COLS - 1),
                                  rand_color());
                    end
                end else begin
                    gen_classify();
                end
            end
            phase++;
        end

        wait_drained();
        steady = 1'b0;
        repeat (TAIL_WAIT) @(posedge clk);
        if (nearest_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", nearest_q.size()));
        end
        if (mismatches == 0) begin
            $display("nearest_palette_color_mapper: match");
        end else begin
            $display("nearest_palette_color_mapper: mismatch");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/npcm_pkg.sv
rtl/core/npcm_dist.sv
rtl/core/nearest_palette_color_mapper.sv
tb/nearest_palette_color_mapper_tb.sv
